[sv/c39m_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39m_pkg
// Shared constants, types and the Code 39 pattern table.
// ----------------------------------------------------------------------------
package c39m_pkg;

    localparam int MAX_BARS_DEF = 32;
    localparam int REF_LENGTH   = 29;
    localparam int SYMBOL_COUNT = 39;
    localparam int LENGTH_SLACK = 10;
    localparam int DW           = 6;
    localparam logic [DW-1:0] DIST_SAT = 6'd63;

    // register indexes of the configuration port
    localparam logic [2:0] REG_BAR_THR  = 3'd0;
    localparam logic [2:0] REG_LINE_THR = 3'd1;
    localparam logic [2:0] REG_MIN_W    = 3'd2;
    localparam logic [2:0] REG_WHITE_TO = 3'd3;
    localparam logic [2:0] REG_ACCEPT   = 3'd4;

    // one hop along the cell row: a narrow/wide bar and two distances
    typedef struct packed {
        logic          v;
        logic          c;
        logic [DW-1:0] val;
        logic [DW-1:0] prv;
    } t_link;

    // every pattern shares the start guard and the tail; only the middle differs.
    // bit set means a wide element, first element at the MSB
    localparam logic [7:0] PAT_HEAD = 8'b01001010;
    localparam logic [8:0] PAT_TAIL = 9'b010010100;

    localparam logic [11:0] PAT_MID [SYMBOL_COUNT] = '{
        12'b000001101000, 12'b001001000010, 12'b000011000010, 12'b001011000000,
        12'b000001100010, 12'b001001100000, 12'b000011100000, 12'b000001001010,
        12'b001001001000, 12'b000011001000, 12'b001000010010, 12'b000010010010,
        12'b001010010000, 12'b000000110010, 12'b001000110000, 12'b000010110000,
        12'b000000011010, 12'b001000011000, 12'b000010011000, 12'b000000111000,
        12'b001000000110, 12'b000010000110, 12'b001010000100, 12'b000000100110,
        12'b001000100100, 12'b000010100100, 12'b000000001110, 12'b001000001100,
        12'b000010001100, 12'b000000101100, 12'b001100000010, 12'b000110000010,
        12'b001110000000, 12'b000100100010, 12'b001100100000, 12'b000110100000,
        12'b000100001010, 12'b001100001000, 12'b001111111100
    };

    function automatic logic [REF_LENGTH-1:0] ref_pattern(input logic [5:0] sym);
        logic [11:0] mid;
        mid = (sym < 6'(SYMBOL_COUNT)) ? PAT_MID[sym] : 12'd0;
        return {PAT_HEAD, mid, PAT_TAIL};
    endfunction

endpackage

[sv/c39m_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39m_cell
// One column of the edit distance table; updates once per bar passing by.
// ----------------------------------------------------------------------------
module c39m_cell #(
    parameter int COL = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_ref,
    input  c39m_pkg::t_link   i_left,
    output c39m_pkg::t_link   o_link
);

    logic                     r_v;
    logic                     r_c;
    logic [c39m_pkg::DW-1:0]  r_val;
    logic [c39m_pkg::DW-1:0]  r_prv;
    logic [c39m_pkg::DW-1:0]  n_val;
    logic [c39m_pkg::DW-1:0]  del_c;
    logic [c39m_pkg::DW-1:0]  ins_c;
    logic [c39m_pkg::DW-1:0]  sub_c;
    logic [c39m_pkg::DW-1:0]  m_c;

    always_comb begin
        del_c = r_val + 1'b1;
        ins_c = i_left.val + 1'b1;
        sub_c = i_left.prv + {{(c39m_pkg::DW-1){1'b0}}, (i_left.c != i_ref)};
        m_c   = (del_c < ins_c) ? del_c : ins_c;
        n_val = (m_c < sub_c) ? m_c : sub_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_load ? 1'b0 : i_left.v;
        end
    end

    // hold the previous row value so the right neighbour sees its diagonal
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= c39m_pkg::DW'(COL);
        end else if (i_left.v) begin
            r_val <= n_val;
            r_prv <= r_val;
            r_c   <= i_left.c;
        end
    end

    assign o_link = '{v: r_v, c: r_c, val: r_val, prv: r_prv};

endmodule

[sv/c39m_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39m_chain
// Row of distance cells, one per reference element.
// ----------------------------------------------------------------------------
module c39m_chain (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [c39m_pkg::REF_LENGTH-1:0]   i_ref,
    input  c39m_pkg::t_link                   i_feed,
    output logic [c39m_pkg::DW-1:0]           o_dist
);

    c39m_pkg::t_link links [c39m_pkg::REF_LENGTH+1];

    assign links[0] = i_feed;

    for (genvar j = 1; j <= c39m_pkg::REF_LENGTH; j++) begin : g_cell
        c39m_cell #(.COL(j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (i_load),
            .i_ref   (i_ref[c39m_pkg::REF_LENGTH-j]),
            .i_left  (links[j-1]),
            .o_link  (links[j])
        );
    end

    assign o_dist = links[c39m_pkg::REF_LENGTH].val;

endmodule

[sv/code39_bar_capture_and_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code39_bar_capture_and_match
// Bar width capture from sample ticks and Code 39 matching by edit distance.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_valid / o_stall) carries one sample tick per word: bar
//  sample, line sample and a microsecond timestamp. A tick that causes no
//  decode leaves the block idle; o_stall stays low while idle.
//  A tick that fills the bar store or ends a long white stretch starts a
//  decode. Two rows of 29 distance cells (bars forward and reversed) run in
//  parallel under a single symbol sequencer; for each of the 39 symbols in
//  turn it loads the cells, feeds the n bars and lets the wavefront drain.
//  A bar count too far from a full symbol to compare skips the symbols and
//  goes straight to the result. o_stall is high throughout the decode.
//  Output channel (o_valid / i_stall) presents one result word per decode.
//  It is held in an output register; a stalled result holds, and the input
//  side keeps taking ticks. A following decode waits for that register.
//  Configuration is a separate write port (always ready) and should only be
//  written while idle.
//  Reset (synchronous, active low) loads the register defaults, stops capture
//  and drops any result in flight.
// ----------------------------------------------------------------------------
module code39_bar_capture_and_match #(
    parameter int MAX_BARS = c39m_pkg::MAX_BARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample ticks
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_bar_sample,
    input  logic [11:0] i_line_sample,
    input  logic [31:0] i_now_us,
    // results
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_symbol_index,
    output logic [5:0]  o_best_distance,
    output logic        o_was_reversed,
    output logic [5:0]  o_bars_seen,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_BARS + 1);
    localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int DW = c39m_pkg::DW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_FEED  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [4:0] DRAIN_LAST = 5'(c39m_pkg::REF_LENGTH + 1);

    // configuration registers
    logic [11:0]   r_bar_thr;
    logic [11:0]   r_line_thr;
    logic [31:0]   r_min_w;
    logic [31:0]   r_white_to;
    logic [DW-1:0] r_accept;

    // capture state
    logic          r_cap;
    logic          r_last;
    logic [31:0]   r_edit;
    logic          r_wt;
    logic [31:0]   r_ws;
    logic [CW-1:0] r_tot;
    logic [31:0]   r_wide;
    logic [31:0]   r_store [MAX_BARS];

    // decode sequencer
    logic [2:0]    r_state;
    logic [CW-1:0] r_dec_n;
    logic [31:0]   r_dec_wide;
    logic [CW-1:0] r_idx;
    logic [4:0]    r_cnt;
    logic [5:0]    r_sym;
    logic [DW-1:0] r_best;
    logic [5:0]    r_best_sym;
    logic          r_best_rev;
    logic          r_feed_v;
    logic [DW-1:0] r_row;
    logic [31:0]   r_rd_f;
    logic [31:0]   r_rd_r;

    // result register
    logic          r_ovalid;
    logic [5:0]    r_o_sym;
    logic [DW-1:0] r_o_dist;
    logic          r_o_rev;
    logic [5:0]    r_o_n;

    // step logic
    logic          acc;
    logic          cur_black;
    logic          line_black;
    logic          n_cap;
    logic          n_last;
    logic [31:0]   n_edit;
    logic          n_wt;
    logic [31:0]   n_ws;
    logic [CW-1:0] n_tot;
    logic [31:0]   n_wide;
    logic          fire;
    logic          wr_en;
    logic [CW-1:0] wr_idx;
    logic [31:0]   wr_data;
    logic [CW-1:0] snap_n;
    logic [31:0]   snap_wide;
    logic          comparable;
    logic [CW-1:0] rev_idx;
    logic          cls_f;
    logic          cls_r;
    logic [34:0]   lim3;
    logic [DW-1:0] dist_f;
    logic [DW-1:0] dist_r;
    logic [DW-1:0] dist_m;
    logic [c39m_pkg::REF_LENGTH-1:0] ref_bits;
    c39m_pkg::t_link feed_f;
    c39m_pkg::t_link feed_r;
    logic          cells_load;
    logic          out_free;

    assign acc         = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || !i_stall;

    // ---------------------------------------------------------------------
    // Configuration writes; unknown indexes drop.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_thr  <= 12'd2000;
            r_line_thr <= 12'd2000;
            r_min_w    <= 32'd1000;
            r_white_to <= 32'd500000;
            r_accept   <= 6'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                c39m_pkg::REG_BAR_THR:  r_bar_thr  <= i_cfg_data[11:0];
                c39m_pkg::REG_LINE_THR: r_line_thr <= i_cfg_data[11:0];
                c39m_pkg::REG_MIN_W:    r_min_w    <= i_cfg_data;
                c39m_pkg::REG_WHITE_TO: r_white_to <= i_cfg_data;
                c39m_pkg::REG_ACCEPT:   r_accept   <= i_cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // One tick: start capture on a black line, close a bar on each colour
    // change, and decide whether a decode runs. A decode clears capture
    // first; the closing colour change and white timing still apply after.
    // ---------------------------------------------------------------------
    always_comb begin
        logic [31:0] w;
        cur_black  = i_bar_sample > r_bar_thr;
        line_black = i_line_sample > r_line_thr;
        n_cap      = r_cap;
        n_last     = r_last;
        n_edit     = r_edit;
        n_wt       = r_wt;
        n_ws       = r_ws;
        n_tot      = r_tot;
        n_wide     = r_wide;
        fire       = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = r_tot;
        w          = i_now_us - n_edit;
        wr_data    = w;
        snap_n     = r_tot;
        snap_wide  = r_wide;

        if (!n_cap && line_black) begin
            n_tot  = '0;
            n_wide = '0;
            n_wt   = 1'b0;
            n_ws   = '0;
            n_cap  = 1'b1;
            n_last = 1'b1;
            n_edit = i_now_us;
        end

        if (n_cap) begin
            if (cur_black != n_last) begin
                w       = i_now_us - n_edit;
                wr_data = w;
                wr_idx  = n_tot;
                if (w > r_min_w && n_tot < CW'(MAX_BARS)) begin
                    wr_en  = 1'b1;
                    n_wide = (w > n_wide) ? w : n_wide;
                    n_tot  = n_tot + 1'b1;
                end
                if (n_tot >= CW'(MAX_BARS)) begin
                    fire      = 1'b1;
                    snap_n    = n_tot;
                    snap_wide = n_wide;
                    n_tot     = '0;
                    n_wide    = '0;
                    n_wt      = 1'b0;
                    n_ws      = '0;
                    n_cap     = 1'b0;
                end
                n_last = cur_black;
                n_edit = i_now_us;
            end
            if (!line_black) begin
                if (!n_wt) begin
                    n_wt = 1'b1;
                    n_ws = i_now_us;
                end else if ((i_now_us - n_ws) > r_white_to) begin
                    fire      = 1'b1;
                    snap_n    = n_tot;
                    snap_wide = n_wide;
                    n_tot     = '0;
                    n_wide    = '0;
                    n_ws      = '0;
                    n_last    = 1'b0;
                    n_cap     = 1'b0;
                    n_wt      = 1'b0;
                end
            end else begin
                n_wt = 1'b0;
            end
        end else begin
            n_wt = 1'b0;
        end
    end

    assign comparable = !((7'(snap_n) + 7'(c39m_pkg::LENGTH_SLACK)
                           < 7'(c39m_pkg::REF_LENGTH))
                       || (7'(snap_n) > 7'(c39m_pkg::REF_LENGTH + c39m_pkg::LENGTH_SLACK)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= 1'b0;
            r_last <= 1'b0;
            r_edit <= '0;
            r_wt   <= 1'b0;
            r_ws   <= '0;
            r_tot  <= '0;
            r_wide <= '0;
        end else if (acc) begin
            r_cap  <= n_cap;
            r_last <= n_last;
            r_edit <= n_edit;
            r_wt   <= n_wt;
            r_ws   <= n_ws;
            r_tot  <= n_tot;
            r_wide <= n_wide;
        end
    end

    // bar store: one write port, two registered read ports (forward, reverse)
    assign rev_idx = r_dec_n - 1'b1 - r_idx;

    always_ff @(posedge i_clk) begin
        if (acc && wr_en) begin
            r_store[wr_idx[AW-1:0]] <= wr_data;
        end
        r_rd_f <= r_store[r_idx[AW-1:0]];
        r_rd_r <= r_store[rev_idx[AW-1:0]];
    end

    // narrow when width*5 <= widest*3
    assign lim3  = {3'b000, r_dec_wide} * 35'd3;
    assign cls_f = ({3'b000, r_rd_f} * 35'd5) > lim3;
    assign cls_r = ({3'b000, r_rd_r} * 35'd5) > lim3;

    assign feed_f = '{v: r_feed_v, c: cls_f, val: r_row, prv: r_row - 1'b1};
    assign feed_r = '{v: r_feed_v, c: cls_r, val: r_row, prv: r_row - 1'b1};

    assign ref_bits   = c39m_pkg::ref_pattern(r_sym);
    assign cells_load = (r_state == S_LOAD);

    c39m_chain u_chain_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cells_load),
        .i_ref   (ref_bits),
        .i_feed  (feed_f),
        .o_dist  (dist_f)
    );

    c39m_chain u_chain_rev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (cells_load),
        .i_ref   (ref_bits),
        .i_feed  (feed_r),
        .o_dist  (dist_r)
    );

    assign dist_m = (dist_f < dist_r) ? dist_f : dist_r;

    // ---------------------------------------------------------------------
    // Decode sequencer: per symbol load the cells, stream the bars, let the
    // wavefront drain, then keep the first strict minimum.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_feed_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_feed_v <= (r_state == S_FEED);
            // load a finished result, otherwise drop the word once taken
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && fire) begin
                        r_state <= comparable ? S_LOAD : S_FIN;
                    end
                end
                S_LOAD: begin
                    r_state <= S_FEED;
                end
                S_FEED: begin
                    if (r_idx == r_dec_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_cnt == DRAIN_LAST) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= (r_sym == 6'(c39m_pkg::SYMBOL_COUNT - 1)) ? S_FIN : S_LOAD;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_row <= DW'(r_idx) + 1'b1;
        unique case (r_state)
            S_IDLE: begin
                r_dec_n    <= snap_n;
                r_dec_wide <= snap_wide;
                r_sym      <= '0;
                r_best     <= c39m_pkg::DIST_SAT;
                r_best_sym <= 6'(c39m_pkg::SYMBOL_COUNT);
                r_best_rev <= 1'b0;
            end
            S_LOAD: begin
                r_idx <= '0;
                r_cnt <= '0;
            end
            S_FEED: begin
                r_idx <= r_idx + 1'b1;
            end
            S_DRAIN: begin
                r_cnt <= r_cnt + 1'b1;
            end
            S_CMP: begin
                if (dist_m < r_best) begin
                    r_best     <= dist_m;
                    r_best_sym <= r_sym;
                    r_best_rev <= (dist_r <= dist_f);
                end
                r_sym <= r_sym + 1'b1;
            end
            S_FIN: begin
                if (out_free) begin
                    if (r_best >= c39m_pkg::DIST_SAT || r_best > r_accept) begin
                        r_o_sym <= 6'(c39m_pkg::SYMBOL_COUNT);
                        r_o_rev <= 1'b0;
                    end else begin
                        r_o_sym <= r_best_sym;
                        r_o_rev <= r_best_rev;
                    end
                    r_o_dist <= r_best;
                    r_o_n    <= 6'(r_dec_n);
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_symbol_index  = r_o_sym;
    assign o_best_distance = r_o_dist;
    assign o_was_reversed  = r_o_rev;
    assign o_bars_seen     = r_o_n;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_tot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot <= CW'(MAX_BARS))
        else $error("bar count beyond store depth");

    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && fire) |=> (r_state != S_IDLE))
        else $error("decode trigger did not start the sequencer");

    a_best_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_best <= $past(r_best)))
        else $error("best distance grew during decode");

    a_nomatch_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_symbol_index == 6'(c39m_pkg::SYMBOL_COUNT)) |-> !o_was_reversed)
        else $error("reverse flag set without a match");

endmodule

[test/code39_bar_capture_and_match_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code39_bar_capture_and_match_tb
// Self-checking bench for the Code 39 bar capture and edit-distance matcher.
// ----------------------------------------------------------------------------
// Sample ticks are sent as whole bar sequences built from the Code 39 table
// (forward or reversed, with a few edits, sometimes padded with random extra
// bars), mixed with stretches of raw noise. A bar-level model of capture and
// matching predicts every decode word, and a scoreboard compares the result
// words field by field. The registers change between phases, extremes too.
// ----------------------------------------------------------------------------
module code39_bar_capture_and_match_tb;

    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [5:0] sym;
        logic [5:0] best;
        logic       rev;
        logic [5:0] bars;
    } t_decode_word;

    // ------------------------------------------------------------------------
    // Bar capture model and store of expected decode words
    // ------------------------------------------------------------------------
    class bar_decode_predictor;
        string pats[39] = '{
            "12112121111112212111121121211", "12112121112112111121121121211",
            "12112121111122111121121121211", "12112121112122111111121121211",
            "12112121111112211121121121211", "12112121112112211111121121211",
            "12112121111122211111121121211", "12112121111112112121121121211",
            "12112121112112112111121121211", "12112121111122112111121121211",
            "12112121112111121121121121211", "12112121111121121121121121211",
            "12112121112121121111121121211", "12112121111111221121121121211",
            "12112121112111221111121121211", "12112121111121221111121121211",
            "12112121111111122121121121211", "12112121112111122111121121211",
            "12112121111121122111121121211", "12112121111111222111121121211",
            "12112121112111111221121121211", "12112121111121111221121121211",
            "12112121112121111211121121211", "12112121111111211221121121211",
            "12112121112111211211121121211", "12112121111121211211121121211",
            "12112121111111112221121121211", "12112121112111112211121121211",
            "12112121111121112211121121211", "12112121111111212211121121211",
            "12112121112211111121121121211", "12112121111221111121121121211",
            "12112121112221111111121121211", "12112121111211211121121121211",
            "12112121112211211111121121211", "12112121111221211111121121211",
            "12112121111211112121121121211", "12112121112211112111121121211",
            "12112121112222222211121121211"
        };

        logic [11:0] bar_thr, line_thr;
        logic [31:0] min_w, white_to;
        logic [5:0]  accept;

        bit          capturing, last_black, white_timing;
        logic [31:0] last_edit, white_start, widest;
        logic [31:0] widths[32];
        int          total;

        t_decode_word pending_decodes[$];
        int mismatches, words_checked;

        function void load_defaults();
            bar_thr = 12'd2000; line_thr = 12'd2000;
            min_w = 32'd1000; white_to = 32'd500000; accept = 6'd10;
            capturing = 0;
            last_edit = '0;
            clear_bars();
        endfunction

        function void clear_bars();
            total = 0; widest = '0; last_black = 0;
            white_timing = 0; white_start = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                c39m_pkg::REG_BAR_THR:  bar_thr = data[11:0];
                c39m_pkg::REG_LINE_THR: line_thr = data[11:0];
                c39m_pkg::REG_MIN_W:    min_w = data;
                c39m_pkg::REG_WHITE_TO: white_to = data;
                c39m_pkg::REG_ACCEPT:   accept = data[5:0];
                default: ;
            endcase
        endfunction

        // edit distance of a narrow/wide string against one symbol
        function int distance_to(byte seq[32], int n, int sym);
            int prev[30], cur[30];
            int del, ins, sub, m;
            if (n + 10 < 29 || n > 39) return 63;
            for (int j = 0; j <= 29; j++) prev[j] = j;
            for (int i = 1; i <= n; i++) begin
                cur[0] = i;
                for (int j = 1; j <= 29; j++) begin
                    del = prev[j] + 1;
                    ins = cur[j-1] + 1;
                    sub = prev[j-1] + ((seq[i-1] == pats[sym][j-1]) ? 0 : 1);
                    m = (del < ins) ? del : ins;
                    cur[j] = (m < sub) ? m : sub;
                end
                prev = cur;
            end
            return (prev[29] > 63) ? 63 : prev[29];
        endfunction

        function void decode();
            byte fwd[32], rev[32];
            int best, sym, rflag, d, r, m;
            t_decode_word w;
            best = 63; sym = 39; rflag = 0;
            for (int i = 0; i < total; i++)
                fwd[i] = ({32'd0, widths[i]} * 5 <= {32'd0, widest} * 3) ? "1" : "2";
            for (int i = 0; i < total; i++) rev[i] = fwd[total-1-i];
            for (int s = 0; s < 39; s++) begin
                d = distance_to(fwd, total, s);
                r = distance_to(rev, total, s);
                m = (d < r) ? d : r;
                if (m < best) begin
                    best = m; sym = s; rflag = (r <= d);
                end
            end
            if (best >= 63 || best > accept) begin
                sym = 39; rflag = 0;
            end
            w.sym = 6'(sym); w.best = 6'(best); w.rev = rflag[0]; w.bars = 6'(total);
            pending_decodes.push_back(w);
            clear_bars();
            capturing = 0;
        endfunction

        function void note_tick(logic [11:0] bar, logic [11:0] line, logic [31:0] now);
            bit cur_black, line_black;
            logic [31:0] w;
            cur_black = bar > bar_thr;
            line_black = line > line_thr;
            if (!capturing && line_black) begin
                clear_bars();
                capturing = 1; last_black = 1; last_edit = now;
            end
            if (capturing) begin
                if (cur_black != last_black) begin
                    w = now - last_edit;
                    if (w > min_w && total < 32) begin
                        widths[total] = w;
                        if (w > widest) widest = w;
                        total++;
                    end
                    if (total >= 32) decode();
                    last_black = cur_black;
                    last_edit = now;
                end
                if (!line_black) begin
                    if (!white_timing) begin
                        white_timing = 1; white_start = now;
                    end else if (now - white_start > white_to) begin
                        decode();
                        white_timing = 0;
                    end
                end else begin
                    white_timing = 0;
                end
            end else begin
                white_timing = 0;
            end
        endfunction

        function bit check_result(t_decode_word got);
            t_decode_word exp_w;
            words_checked++;
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected decode word sym=%0d dist=%0d rev=%0d bars=%0d",
                             got.sym, got.best, got.rev, got.bars);
                return 0;
            end
            exp_w = pending_decodes.pop_front();
            if (got.sym !== exp_w.sym || got.best !== exp_w.best ||
                got.rev !== exp_w.rev || got.bars !== exp_w.bars) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: decode word exp sym=%0d dist=%0d rev=%0d bars=%0d,",
                              " got sym=%0d dist=%0d rev=%0d bars=%0d"},
                             exp_w.sym, exp_w.best, exp_w.rev, exp_w.bars,
                             got.sym, got.best, got.rev, got.bars);
                return 0;
            end
            return 1;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and handshake signals
    // ------------------------------------------------------------------------
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [11:0] i_bar_sample = '0;
    logic [11:0] i_line_sample = '0;
    logic [31:0] i_now_us = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [5:0]  o_symbol_index, o_best_distance, o_bars_seen;
    logic        o_was_reversed;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    code39_bar_capture_and_match u_top (.*);

    bar_decode_predictor decodes = new();

    bit          idling_on = 1;
    int          ticks_sent, phases_run, stall_left, dog;
    logic [31:0] stamp_us;
    logic [11:0] bar_now;

    // Receiver side: hold off results in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall = 1;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_stall = 1;
        end else begin
            i_stall = 0;
        end
    end

    // Check every accepted result word; bark when nothing moves for too long
    always @(posedge i_clk) begin
        t_decode_word got;
        if (o_valid && !i_stall) begin
            got.sym = o_symbol_index; got.best = o_best_distance;
            got.rev = o_was_reversed; got.bars = o_bars_seen;
            void'(decodes.check_result(got));
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            dog = 0;
        else
            dog++;
        if (dog >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, nothing accepted for %0d cycles", dog);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sample value of a wanted colour for a given threshold
    function automatic logic [11:0] sample_for(bit black, logic [11:0] thr);
        if (black)
            return (thr == 12'hFFF) ? 12'hFFF : 12'($urandom_range(4095, thr + 1));
        return 12'($urandom_range(thr, 0));
    endfunction

    // Present one sample tick and hold it until taken
    task automatic send_tick(logic [11:0] bar, logic [11:0] line, logic [31:0] now);
        if (idling_on && $urandom_range(0, 11) == 0) begin
            @(negedge i_clk);
            i_valid = 0;
            repeat ($urandom_range(0, 18)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1;
        i_bar_sample = bar; i_line_sample = line; i_now_us = now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decodes.note_tick(bar, line, now);
        ticks_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_valid = 0;
        i_cfg_valid = 1; i_cfg_index = idx; i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        decodes.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // Let every pending decode come out, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        i_valid = 0;
        while (decodes.pending_decodes.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_phase(logic [11:0] bt, logic [11:0] lt, logic [31:0] mw,
                             logic [31:0] wt, logic [5:0] acc);
        drain();
        write_reg(c39m_pkg::REG_BAR_THR, {20'($urandom), bt});
        write_reg(c39m_pkg::REG_LINE_THR, {20'($urandom), lt});
        write_reg(c39m_pkg::REG_MIN_W, mw);
        write_reg(c39m_pkg::REG_WHITE_TO, wt);
        write_reg(c39m_pkg::REG_ACCEPT, {26'($urandom), acc});
        write_reg(REG_SPARE_LO, $urandom);
        phases_run++;
    endtask

    // Raw noise: random samples, random small time steps
    task automatic send_noise(int count);
        for (int k = 0; k < count; k++) begin
            stamp_us += $urandom_range(0, 6000);
            send_tick(12'($urandom), 12'($urandom), stamp_us);
        end
    endtask

    // One scanned symbol: start on a black line, then one tick per bar edge,
    // then white line ticks to close it
    task automatic send_symbol(int sym, bit reversed, int edits, int pad);
        bit          wide[$];
        int          pos;
        logic [31:0] narrow, w;
        bit          black;
        for (int i = 0; i < 29; i++) wide.push_back(decodes.pats[sym][i] == "2");
        if (reversed) wide.reverse();
        for (int e = 0; e < edits; e++) begin
            pos = $urandom_range(0, wide.size() - 1);
            case ($urandom_range(0, 2))
                0: wide[pos] = ~wide[pos];
                1: wide.insert(pos, $urandom_range(0, 1));
                default: wide.delete(pos);
            endcase
        end
        for (int p = 0; p < pad; p++) wide.push_back($urandom_range(0, 1));
        narrow = (decodes.min_w < 32'd50000) ? decodes.min_w + 1 + $urandom_range(0, 400)
                                             : 32'd1000;
        if ($urandom_range(0, 7) == 0) stamp_us = 32'hFFFF_FFFF - $urandom_range(0, 60000);
        bar_now = sample_for(1, decodes.bar_thr);
        send_tick(bar_now, sample_for(1, decodes.line_thr), stamp_us);
        black = 1;
        foreach (wide[k]) begin
            w = wide[k] ? narrow * 3 - $urandom_range(0, narrow / 4)
                        : narrow + $urandom_range(0, narrow / 10);
            stamp_us += w;
            black = ~black;
            bar_now = sample_for(black, decodes.bar_thr);
            send_tick(bar_now, sample_for(1, decodes.line_thr), stamp_us);
        end
        // hold the bar colour and go white on the line
        stamp_us += narrow;
        send_tick(sample_for(black, decodes.bar_thr), sample_for(0, decodes.line_thr), stamp_us);
        if (decodes.white_to < 32'h1000_0000) begin
            stamp_us += decodes.white_to + 1 + $urandom_range(0, 100);
            send_tick(sample_for(black, decodes.bar_thr), sample_for(0, decodes.line_thr),
                      stamp_us);
        end
    endtask

    task automatic random_phase(int quota);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < quota) begin
            if ($urandom_range(0, 9) < 2)
                send_noise($urandom_range(1, 8));
            else
                send_symbol($urandom_range(0, 38), $urandom_range(0, 1),
                            ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0);
        end
    endtask

    initial begin
        decodes.load_defaults();
        stamp_us = $urandom;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, wrapped bar widths, a decode with too few bars
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        write_reg(c39m_pkg::REG_WHITE_TO, 32'd5000);
        send_tick(12'h000, 12'h000, 32'h0000_0000);
        send_tick(12'hFFF, 12'hFFF, 32'hFFFF_FFF0);
        send_tick(12'h000, 12'hFFF, 32'h0000_0100);
        send_tick(12'hFFF, 12'hFFF, 32'h0000_1000);
        send_tick(12'h000, 12'hFFF, 32'h0000_3000);
        send_tick(12'h000, 12'h000, 32'h0000_3100);
        send_tick(12'h000, 12'h000, 32'hFFFF_FFFF);
        send_tick(12'hFFF, 12'hFFF, 32'h0000_0000);
        send_tick(12'hAAA, 12'h555, 32'hAAAA_AAAA);
        send_tick(12'h555, 12'hAAA, 32'h5555_5555);
        send_tick(12'h000, 12'h000, 32'h5556_0000);
        send_tick(12'h000, 12'h000, 32'h5557_0000);

        // Random phases across register settings
        set_phase(12'd2000, 12'd2000, 32'd1000, 32'd5000, 6'd10);
        random_phase(340);
        set_phase(12'd0, 12'd0, 32'd0, 32'd0, 6'd63);
        random_phase(340);
        set_phase(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        send_noise(60);
        set_phase(12'd1234, 12'd3000, 32'd500, 32'd20000, 6'd0);
        random_phase(430);
        set_phase(12'd3000, 12'd100, 32'd2000, 32'd1000, 6'd5);
        random_phase(240);
        // last stretch with both sides flat out
        drain();
        idling_on = 0;
        random_phase(300);

        drain();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d sample ticks over %0d register settings; %0d decode words checked.",
                 ticks_sent, phases_run + 1, decodes.words_checked);
        if (decodes.pending_decodes.size() != 0) begin
            decodes.mismatches++;
            $display("ERROR: %0d decode words never arrived", decodes.pending_decodes.size());
        end
        if (decodes.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", decodes.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
